### sv/ifr_pkg.sv
// ----------------------------------------------------------------------------
// ifr_pkg
// Shared types and constants for the image frame receiver: phase codes,
// register indexes and the word that passes from front end to back end.
// ----------------------------------------------------------------------------
`default_nettype none

package ifr_pkg;

    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned LEN_W       = 31;

    localparam logic [31:0] LOAD_BASE_RESET  = 32'h0008_0000;
    localparam logic [31:0] RETRY_ADDR_RESET = 32'h0006_0000;

    // Byte phase within a frame
    typedef enum logic [1:0] {
        PH_LENGTH   = 2'd0,
        PH_CHECKSUM = 2'd1,
        PH_PAYLOAD  = 2'd2
    } frame_phase_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LOAD_BASE  = 4'd0,
        REG_RETRY_ADDR = 4'd1
    } cfg_reg_t;

    // Classified byte handed from front end to back end.
    // last: length phase -> length word complete; checksum phase -> empty frame
    // ends here; payload phase -> final payload byte.
    typedef struct packed {
        frame_phase_t     phase;
        logic             last;
        logic [LEN_W-1:0] index;
        logic [7:0]       data;
    } ifr_op_t;

endpackage : ifr_pkg

`default_nettype wire

### sv/ifr_front.sv
// ----------------------------------------------------------------------------
// ifr_front
// Front end: tracks the frame header and payload count and tags each
// received byte with its phase, payload index and end-of-section flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ifr_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            byte_valid,
    input  wire logic [7:0]      byte_data,
    output ifr_pkg::ifr_op_t     op
);
    import ifr_pkg::*;

    frame_phase_t     phase_reg, phase_next;
    logic [1:0]       hcount_reg, hcount_next;
    logic [31:0]      shift_reg, shift_next;
    logic [LEN_W-1:0] length_reg, length_next;
    logic [LEN_W-1:0] index_reg, index_next;
    logic [LEN_W-1:0] index_inc;

    assign index_inc = index_reg + 1'b1;

    // Classify the current byte and work out the next header state
    always_comb begin
        phase_next  = phase_reg;
        hcount_next = hcount_reg;
        shift_next  = shift_reg;
        length_next = length_reg;
        index_next  = index_reg;
        op.phase    = PH_LENGTH;
        op.last     = 1'b0;
        op.index    = '0;
        op.data     = byte_data;
        unique case (phase_reg)
            PH_CHECKSUM: begin
                op.phase    = PH_CHECKSUM;
                hcount_next = hcount_reg + 1'b1;
                if (hcount_reg == 2'd3) begin
                    index_next = '0;
                    if (length_reg == '0) begin
                        op.last    = 1'b1;
                        phase_next = PH_LENGTH;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                op.phase   = PH_PAYLOAD;
                op.index   = index_reg;
                index_next = index_inc;
                if (index_inc >= length_reg) begin
                    op.last     = 1'b1;
                    phase_next  = PH_LENGTH;
                    hcount_next = 2'd0;
                    shift_next  = '0;
                end
            end
            default: begin
                op.phase    = PH_LENGTH;
                phase_next  = PH_LENGTH;
                shift_next  = {shift_reg[23:0], byte_data};
                hcount_next = hcount_reg + 1'b1;
                if (hcount_reg == 2'd3) begin
                    op.last     = 1'b1;
                    length_next = shift_next[31] ? '0 : shift_next[LEN_W-1:0];
                    shift_next  = '0;
                    phase_next  = PH_CHECKSUM;
                end
            end
        endcase
    end

    // Header state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_LENGTH;
            hcount_reg <= '0;
            shift_reg  <= '0;
            length_reg <= '0;
            index_reg  <= '0;
        end else if (byte_valid) begin
            phase_reg  <= phase_next;
            hcount_reg <= hcount_next;
            shift_reg  <= shift_next;
            length_reg <= length_next;
            index_reg  <= index_next;
        end
    end

endmodule : ifr_front

`default_nettype wire

### sv/ifr_queue.sv
// ----------------------------------------------------------------------------
// ifr_queue
// Two-entry queue between front end and back end; push and pop may occur
// in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ifr_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  ifr_pkg::ifr_op_t     push_op,
    output logic                 not_full,
    input  wire logic            pop,
    output ifr_pkg::ifr_op_t     head_op,
    output logic                 not_empty
);
    import ifr_pkg::*;

    ifr_op_t     entry_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg, count_next;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_op   = entry_reg[rd_ptr_reg];

    // Occupancy
    always_comb begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule : ifr_queue

`default_nettype wire

### sv/ifr_back.sv
// ----------------------------------------------------------------------------
// ifr_back
// Back end: keeps the running checksum, forms store addresses and the
// end-of-frame verdict, and holds each result word in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ifr_back #(
    parameter int unsigned ADDR_WIDTH = 32
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  ifr_pkg::ifr_op_t     op,
    input  wire logic            op_valid,
    output logic                 op_pop,
    input  wire logic [31:0]     load_base,
    input  wire logic [31:0]     retry_addr,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic                 m_mem_write,
    output logic [31:0]          m_mem_addr,
    output logic [7:0]           m_mem_data,
    output logic [1:0]           m_frame_phase,
    output logic                 m_done_res,
    output logic                 m_checksum_ok,
    output logic [31:0]          m_jump_addr
);
    import ifr_pkg::*;

    localparam int unsigned ADDR_KEEP = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
    localparam logic [63:0] ADDR_MASK64 = (64'd1 << ADDR_KEEP) - 64'd1;
    localparam logic [31:0] ADDR_MASK   = ADDR_MASK64[31:0];

    logic [31:0] sum_reg, sum_next;
    logic        valid_reg;
    logic        write_reg, write_next;
    logic [31:0] addr_reg, addr_next;
    logic [7:0]  data_reg, data_next;
    logic [1:0]  phase_reg;
    logic        done_reg, done_next;
    logic        ok_reg, ok_next;
    logic [31:0] jump_reg, jump_next;

    assign op_pop = op_valid && (!valid_reg || m_ready);

    // Checksum update and result word
    always_comb begin
        sum_next   = sum_reg;
        write_next = 1'b0;
        addr_next  = '0;
        data_next  = '0;
        done_next  = 1'b0;
        unique case (op.phase)
            PH_CHECKSUM: begin
                sum_next  = {sum_reg[23:0], op.data};
                done_next = op.last;
            end
            PH_PAYLOAD: begin
                sum_next   = sum_reg - {24'd0, op.data};
                write_next = 1'b1;
                addr_next  = (load_base + {1'b0, op.index}) & ADDR_MASK;
                data_next  = op.data;
                done_next  = op.last;
            end
            default: begin
                if (op.last) begin
                    sum_next = '0;
                end
            end
        endcase
        ok_next   = done_next && (sum_next == '0);
        jump_next = '0;
        if (done_next) begin
            jump_next = ok_next ? load_base : retry_addr;
        end
    end

    // Running checksum and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (op_pop) begin
                sum_reg   <= sum_next;
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (op_pop) begin
            write_reg <= write_next;
            addr_reg  <= addr_next;
            data_reg  <= data_next;
            phase_reg <= op.phase;
            done_reg  <= done_next;
            ok_reg    <= ok_next;
            jump_reg  <= jump_next;
        end
    end

    assign m_valid       = valid_reg;
    assign m_mem_write   = write_reg;
    assign m_mem_addr    = addr_reg;
    assign m_mem_data    = data_reg;
    assign m_frame_phase = phase_reg;
    assign m_done_res    = done_reg;
    assign m_checksum_ok = ok_reg;
    assign m_jump_addr   = jump_reg;

endmodule : ifr_back

`default_nettype wire

### sv/image_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// image_frame_receiver_top
// Length-prefixed image frame receiver with additive 32-bit checksum.
// ----------------------------------------------------------------------------
// Takes one received byte per clock when m_ready is high and returns one
// result word per byte. A frame is a 4-byte big-endian length, a 4-byte
// big-endian checksum and that many payload bytes; each payload byte comes
// out as a store to load_base plus its index, and the last byte of the
// frame carries done, checksum_ok and the jump address. Sustained rate is
// one byte per cycle while m_ready is high: the front end classifies a byte
// against the header counters, a two-word queue holds it, and the back end
// updates the running sum (one 32-bit subtract and zero compare) into the
// output register. Configuration writes are always accepted and apply to
// bytes popped later; write them only while no frame bytes are in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module image_frame_receiver_top #(
    parameter int unsigned ADDR_WIDTH = 32
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [7:0]                       s_rx_byte,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_mem_write,
    output logic [31:0]                           m_mem_addr,
    output logic [7:0]                            m_mem_data,
    output logic [1:0]                            m_frame_phase,
    output logic                                  m_done_res,
    output logic                                  m_checksum_ok,
    output logic [31:0]                           m_jump_addr,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ifr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [31:0]                      cfg_data
);
    import ifr_pkg::*;

    logic [31:0] load_base_reg, retry_addr_reg;
    ifr_op_t     front_op, head_op;
    logic        q_not_full, q_not_empty, q_pop, in_accept;

    assign cfg_ready     = 1'b1;
    assign s_ready       = q_not_full;
    assign in_accept     = s_valid && q_not_full;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_base_reg  <= LOAD_BASE_RESET;
            retry_addr_reg <= RETRY_ADDR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_LOAD_BASE:  load_base_reg  <= cfg_data;
                REG_RETRY_ADDR: retry_addr_reg <= cfg_data;
                default: begin
                    load_base_reg <= load_base_reg;
                end
            endcase
        end
    end

    ifr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (in_accept),
        .byte_data  (s_rx_byte),
        .op         (front_op)
    );

    ifr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_accept),
        .push_op   (front_op),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .head_op   (head_op),
        .not_empty (q_not_empty)
    );

    ifr_back #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .op            (head_op),
        .op_valid      (q_not_empty),
        .op_pop        (q_pop),
        .load_base     (load_base_reg),
        .retry_addr    (retry_addr_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_mem_write   (m_mem_write),
        .m_mem_addr    (m_mem_addr),
        .m_mem_data    (m_mem_data),
        .m_frame_phase (m_frame_phase),
        .m_done_res    (m_done_res),
        .m_checksum_ok (m_checksum_ok),
        .m_jump_addr   (m_jump_addr)
    );

endmodule : image_frame_receiver_top

`default_nettype wire
